@@ hdl/frequency_ordered_list_macros.svh @@
// ---------------------------------------------------------------------------
// Frequency-ordered list assertion macros
// Concurrent check wrappers; they compile away when SYNTHESIS is defined.
// They expect ports named i_clk and i_rst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define FOL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check that a condition in one cycle implies a condition in the next.
`define FOL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define FOL_ASSERT(lbl, prop, msg)
`define FOL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hdl/fol_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frequency-ordered list package
// Sizes, request and response types, codes and the controller/datapath
// command and status groups.
// ---------------------------------------------------------------------------
package fol_pkg;

    localparam int DEPTH       = 32;
    localparam int COUNT_WIDTH = 16;
    localparam int AW          = $clog2(DEPTH);
    localparam int LEN_W       = AW + 1;
    localparam int POS_W       = 5;
    localparam int CMP_W       = (POS_W > LEN_W) ? POS_W : LEN_W;

    typedef logic [AW-1:0]          t_addr;
    typedef logic [LEN_W-1:0]       t_len;
    typedef logic [CMP_W-1:0]       t_cmp;
    typedef logic [POS_W-1:0]       t_pos;
    typedef logic [COUNT_WIDTH-1:0] t_count;
    typedef logic [15:0]            t_cnt_out;
    typedef logic [31:0]            t_value;

    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        K_LOAD   = 2'd0,
        K_ACCESS = 2'd1,
        K_READ   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_BEYOND    = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] key_value;
        logic [4:0]         read_position;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [4:0]         position;
        logic signed [31:0] entry_value;
        logic [15:0]        entry_count;
    } t_rsp;

    typedef struct packed {
        t_value value;
        t_count count;
    } t_entry;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_LOAD_OK,
        RES_FULL,
        RES_MISS,
        RES_MOVED,
        RES_READ,
        RES_BEYOND
    } t_res_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOAD,
        S_SEARCH,
        S_MOVE,
        S_PLACE,
        S_MISS,
        S_RD_ISSUE,
        S_RD_DATA,
        S_BEYOND,
        S_NONE
    } t_state;

    typedef struct packed {
        logic     capture;
        logic     search;
        logic     latch_hit;
        logic     move;
        logic     rd_issue;
        logic     append;
        logic     place;
        logic     out_load;
        t_res_sel out_sel;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       full;
        logic       beyond;
        logic       hit;
        logic       miss;
        logic       move_done;
        logic       out_free;
    } t_stat;

endpackage

@@ hdl/fol_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, registered read data that holds while
// no read is enabled.
// ---------------------------------------------------------------------------
module fol_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/fol_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frequency-ordered list controller
// Sequences one request at a time through dispatch, search, reorder and
// response, and drives the datapath commands.
// ---------------------------------------------------------------------------
module fol_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  fol_pkg::t_stat i_stat,
    output fol_pkg::t_cmd  o_cmd
);

    fol_pkg::t_state r_state;
    fol_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fol_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fol_pkg::S_IDLE: begin
                if (i_req_valid) begin
                    n_state = fol_pkg::S_DISPATCH;
                end
            end
            fol_pkg::S_DISPATCH: begin
                case (i_stat.kind)
                    fol_pkg::K_LOAD:   n_state = fol_pkg::S_LOAD;
                    fol_pkg::K_ACCESS: n_state = fol_pkg::S_SEARCH;
                    fol_pkg::K_READ: begin
                        n_state = i_stat.beyond ? fol_pkg::S_BEYOND : fol_pkg::S_RD_ISSUE;
                    end
                    default:           n_state = fol_pkg::S_NONE;
                endcase
            end
            fol_pkg::S_SEARCH: begin
                if (i_stat.hit) begin
                    n_state = fol_pkg::S_MOVE;
                end else if (i_stat.miss) begin
                    n_state = fol_pkg::S_MISS;
                end
            end
            fol_pkg::S_MOVE: begin
                if (i_stat.move_done) begin
                    n_state = fol_pkg::S_PLACE;
                end
            end
            fol_pkg::S_RD_ISSUE: n_state = fol_pkg::S_RD_DATA;
            fol_pkg::S_LOAD, fol_pkg::S_PLACE, fol_pkg::S_MISS,
            fol_pkg::S_RD_DATA, fol_pkg::S_BEYOND, fol_pkg::S_NONE: begin
                if (i_stat.out_free) begin
                    n_state = fol_pkg::S_IDLE;
                end
            end
            default: n_state = fol_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = fol_pkg::RES_NONE;
        o_req_ready   = 1'b0;
        case (r_state)
            fol_pkg::S_IDLE: begin
                o_req_ready   = 1'b1;
                o_cmd.capture = i_req_valid;
            end
            fol_pkg::S_LOAD: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.append   = i_stat.out_free && !i_stat.full;
                o_cmd.out_sel  = i_stat.full ? fol_pkg::RES_FULL : fol_pkg::RES_LOAD_OK;
            end
            fol_pkg::S_SEARCH: begin
                o_cmd.search    = 1'b1;
                o_cmd.latch_hit = i_stat.hit;
            end
            fol_pkg::S_MOVE: begin
                o_cmd.move = 1'b1;
            end
            fol_pkg::S_PLACE: begin
                o_cmd.place    = i_stat.out_free;
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = fol_pkg::RES_MOVED;
            end
            fol_pkg::S_MISS: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = fol_pkg::RES_MISS;
            end
            fol_pkg::S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
            end
            fol_pkg::S_RD_DATA: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = fol_pkg::RES_READ;
            end
            fol_pkg::S_BEYOND: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = fol_pkg::RES_BEYOND;
            end
            fol_pkg::S_NONE: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_sel  = fol_pkg::RES_NONE;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/fol_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frequency-ordered list datapath
// Table RAM, request registers, scan pointer, hole tracking for the
// reorder shift, and the response register.
// ---------------------------------------------------------------------------
`include "frequency_ordered_list_macros.svh"

module fol_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fol_pkg::t_req  i_req,
    input  fol_pkg::t_cmd  i_cmd,
    output fol_pkg::t_stat o_stat,
    input  logic           i_rsp_ready,
    output logic           o_rsp_valid,
    output fol_pkg::t_rsp  o_rsp
);

    // Control registers
    fol_pkg::t_len   r_len;
    logic            r_dv;
    logic            r_out_vld;

    // Payload registers
    logic [1:0]      r_kind;
    fol_pkg::t_value r_key;
    fol_pkg::t_pos   r_rpos;
    fol_pkg::t_len   r_ptr;
    fol_pkg::t_len   n_ptr;
    fol_pkg::t_addr  r_daddr;
    fol_pkg::t_addr  r_hole;
    fol_pkg::t_count r_cnt;
    logic            r_up;
    fol_pkg::t_rsp   r_rsp;
    fol_pkg::t_rsp   n_rsp;

    // RAM port
    fol_pkg::t_entry w_rdata;
    fol_pkg::t_entry w_wdata;
    fol_pkg::t_addr  w_waddr;
    fol_pkg::t_addr  w_raddr;
    logic            w_we;
    logic            w_re;
    logic [2:0]      w_wr_sel;

    logic ptr_lt_len;
    logic in_range;
    logic hit;
    logic pass;
    logic pass_w;
    logic move_done;
    logic issue_s;
    logic issue_m;
    logic sat;
    logic full;
    logic beyond;

    always_comb begin
        ptr_lt_len = r_ptr < r_len;
        // Downward scan runs off the table when the pointer wraps below zero.
        in_range   = r_up ? ptr_lt_len : !r_ptr[fol_pkg::AW];
        hit        = r_dv && (w_rdata.value == r_key);
        pass       = r_dv && (r_up ? (w_rdata.count >= r_cnt) : (w_rdata.count < r_cnt));
        move_done  = (r_dv && !pass) || (!r_dv && !in_range);
        issue_s    = i_cmd.search && ptr_lt_len && !hit;
        issue_m    = i_cmd.move && in_range && !move_done;
        pass_w     = i_cmd.move && pass;
        sat        = w_rdata.count == fol_pkg::COUNT_MAX;
        full       = r_len >= fol_pkg::t_len'(fol_pkg::DEPTH);
        beyond     = fol_pkg::t_cmp'(r_rpos) >= fol_pkg::t_cmp'(r_len);
    end

    // Write port: shifted entry, placed entry or appended entry
    always_comb begin
        w_wr_sel = {pass_w, i_cmd.place, i_cmd.append};
        w_we     = pass_w || i_cmd.place || i_cmd.append;
        w_waddr  = i_cmd.append ? r_len[fol_pkg::AW-1:0] : r_hole;
        if (pass_w) begin
            w_wdata = w_rdata;
        end else begin
            w_wdata.value = r_key;
            w_wdata.count = i_cmd.append ? '0 : r_cnt;
        end
    end

    assign w_re    = issue_s || issue_m || i_cmd.rd_issue;
    assign w_raddr = i_cmd.rd_issue ? fol_pkg::t_addr'(r_rpos) : r_ptr[fol_pkg::AW-1:0];

    fol_ram #(
        .WIDTH ($bits(fol_pkg::t_entry)),
        .DEPTH (fol_pkg::DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.capture) begin
            n_ptr = '0;
        end else if (i_cmd.latch_hit) begin
            n_ptr = sat ? fol_pkg::t_len'(r_daddr) + fol_pkg::t_len'(1)
                        : fol_pkg::t_len'(r_daddr) - fol_pkg::t_len'(1);
        end else if (issue_s || (issue_m && r_up)) begin
            n_ptr = r_ptr + fol_pkg::t_len'(1);
        end else if (issue_m) begin
            n_ptr = r_ptr - fol_pkg::t_len'(1);
        end
    end

    always_comb begin
        n_rsp = r_rsp;
        if (i_cmd.out_load) begin
            n_rsp = '0;
            case (i_cmd.out_sel)
                fol_pkg::RES_LOAD_OK: begin
                    n_rsp.status      = fol_pkg::ST_OK;
                    n_rsp.position    = fol_pkg::t_pos'(r_len);
                    n_rsp.entry_value = r_key;
                end
                fol_pkg::RES_FULL: begin
                    n_rsp.status      = fol_pkg::ST_FULL;
                    n_rsp.entry_value = r_key;
                end
                fol_pkg::RES_MISS: begin
                    n_rsp.status      = fol_pkg::ST_NOT_FOUND;
                    n_rsp.entry_value = r_key;
                end
                fol_pkg::RES_MOVED: begin
                    n_rsp.status      = fol_pkg::ST_OK;
                    n_rsp.position    = fol_pkg::t_pos'(r_hole);
                    n_rsp.entry_value = r_key;
                    n_rsp.entry_count = fol_pkg::t_cnt_out'(r_cnt);
                end
                fol_pkg::RES_READ: begin
                    n_rsp.status      = fol_pkg::ST_OK;
                    n_rsp.position    = r_rpos;
                    n_rsp.entry_value = w_rdata.value;
                    n_rsp.entry_count = fol_pkg::t_cnt_out'(w_rdata.count);
                end
                fol_pkg::RES_BEYOND: begin
                    n_rsp.status = fol_pkg::ST_BEYOND;
                end
                default: begin
                    n_rsp.status = fol_pkg::ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_dv      <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_dv <= issue_s || issue_m;
            if (i_cmd.append) begin
                r_len <= r_len + fol_pkg::t_len'(1);
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr   <= n_ptr;
        r_daddr <= r_ptr[fol_pkg::AW-1:0];
        r_rsp   <= n_rsp;
        if (i_cmd.capture) begin
            r_kind <= i_req.kind;
            r_key  <= i_req.key_value;
            r_rpos <= i_req.read_position;
        end
        if (i_cmd.latch_hit) begin
            r_hole <= r_daddr;
            r_up   <= sat;
            r_cnt  <= sat ? w_rdata.count : w_rdata.count + fol_pkg::t_count'(1);
        end else if (pass_w) begin
            r_hole <= r_daddr;
        end
    end

    always_comb begin
        o_stat.kind      = r_kind;
        o_stat.full      = full;
        o_stat.beyond    = beyond;
        o_stat.hit       = hit;
        o_stat.miss      = !r_dv && !ptr_lt_len;
        o_stat.move_done = move_done;
        o_stat.out_free  = !r_out_vld || i_rsp_ready;
    end

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_rsp;

    `FOL_ASSERT(a_len_bound, r_len <= fol_pkg::t_len'(fol_pkg::DEPTH), "table length beyond depth")
    `FOL_ASSERT(a_one_writer, $onehot0(w_wr_sel), "more than one table write source")
    `FOL_ASSERT(a_append_room, i_cmd.append |-> !full, "append into a full table")
    `FOL_ASSERT_NEXT(a_place_rsp, i_cmd.place, r_out_vld, "placed entry without response")
    `FOL_ASSERT_NEXT(a_hit_flush, i_cmd.latch_hit, !r_dv, "stale read in flight after hit")

endmodule

@@ hdl/frequency_ordered_list.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frequency-ordered list
// Table of values with access counts, kept in order of non-increasing count.
// ---------------------------------------------------------------------------
// The block takes one request at a time and returns exactly one response per
// request. A load appends the key at the end of the table, unless it is full;
// a read returns the entry at the given position, unless it lies beyond the
// current length; an access searches the table from the head, and on a hit
// shifts the entries that the hit entry moves past and places it. The search
// reads one entry per cycle through the single read port of the table RAM,
// and the reorder moves one entry per cycle. Each response state holds while
// the output register stays occupied. The response sits in an output
// register, so the next request is taken once the block is back in idle,
// even if the previous response has not been drained yet. The table needs
// no clearing after reset, because only entries below the current length
// are ever read.
// ---------------------------------------------------------------------------
module frequency_ordered_list (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  fol_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output fol_pkg::t_rsp o_rsp
);

    // Command and status between sequencer and datapath
    fol_pkg::t_cmd  w_cmd;
    fol_pkg::t_stat w_stat;

    // Controller: dispatch on request kind, then step the search, the
    // reorder shift and the response load; hold in a response state while
    // the output register is still occupied.
    fol_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath: table RAM, scan pointer, hole pointer for the shift, and
    // the response register. A hit moves the entry toward the head past
    // lower counts; at a saturated count it moves toward the tail past
    // other saturated entries instead.
    fol_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_rsp       (o_rsp)
    );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Frequency-ordered list testbench
// Drives load, access and read requests through the valid/ready channels,
// predicts every response with a model of the count-ordered table and
// checks each field. The run has a directed table, a long random stretch, a
// back-to-back stretch that pushes one entry toward the head, and a random end.
// ---------------------------------------------------------------------------
module tb_top;

    import fol_pkg::*;

    // The fourth kind encoding has no enum member; the block answers it with zeros.
    localparam logic [1:0] K_UNUSED = 2'd3;

    // Worst-case busy time of one request, used for the final drain.
    localparam int DRAIN_CYCLES = 2 * DEPTH + 16;

    // One row of directed stimulus. A row may repeat with key and position
    // stepping by one. Where the response is obvious it is typed in the row.
    typedef struct {
        t_req   req;
        int     reps;
        bit     typed;
        t_rsp   want;
    } t_directed_row;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    t_req req       = '0;
    logic rsp_ready = 1'b0;
    logic o_req_ready;
    logic o_rsp_valid;
    t_rsp o_rsp;

    // Model copy of the table, updated in request accept order.
    t_value tbl_value [DEPTH];
    t_count tbl_count [DEPTH];
    int     tbl_len = 0;

    t_rsp          expected_rsp [$];
    t_directed_row directed_rows [$];
    int            mismatch_count = 0;
    bit            idle_on = 1'b1;

    frequency_ordered_list u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Apply one request to the model table and return the response it causes.
    function automatic t_rsp access_table(input t_req r);
        t_rsp   rsp;
        t_value key;
        t_count cnt;
        int     hit;
        int     dest;
        rsp = '0;
        key = r.key_value;
        case (r.kind)
            K_LOAD: begin
                rsp.entry_value = key;
                if (tbl_len >= DEPTH) begin
                    rsp.status = ST_FULL;
                end else begin
                    tbl_value[tbl_len] = key;
                    tbl_count[tbl_len] = '0;
                    rsp.status   = ST_OK;
                    rsp.position = t_pos'(tbl_len);
                    tbl_len++;
                end
            end
            K_ACCESS: begin
                // Find the first entry holding the key.
                hit = -1;
                for (int i = 0; i < tbl_len; i++) begin
                    if (hit < 0 && tbl_value[i] == key) begin
                        hit = i;
                    end
                end
                rsp.entry_value = key;
                if (hit < 0) begin
                    rsp.status = ST_NOT_FOUND;
                end else begin
                    cnt = tbl_count[hit];
                    if (cnt != COUNT_MAX) begin
                        cnt++;
                    end
                    // Close the gap, skip every entry with an equal or
                    // larger count, then reopen a slot there.
                    for (int i = hit; i + 1 < tbl_len; i++) begin
                        tbl_value[i] = tbl_value[i + 1];
                        tbl_count[i] = tbl_count[i + 1];
                    end
                    dest = 0;
                    while (dest + 1 < tbl_len && tbl_count[dest] >= cnt) begin
                        dest++;
                    end
                    for (int i = tbl_len - 1; i > dest; i--) begin
                        tbl_value[i] = tbl_value[i - 1];
                        tbl_count[i] = tbl_count[i - 1];
                    end
                    tbl_value[dest] = key;
                    tbl_count[dest] = cnt;
                    rsp.status      = ST_OK;
                    rsp.position    = t_pos'(dest);
                    rsp.entry_count = t_cnt_out'(cnt);
                end
            end
            K_READ: begin
                if (int'(r.read_position) >= tbl_len) begin
                    rsp.status = ST_BEYOND;
                end else begin
                    rsp.status      = ST_OK;
                    rsp.position    = r.read_position;
                    rsp.entry_value = tbl_value[r.read_position];
                    rsp.entry_count = t_cnt_out'(tbl_count[r.read_position]);
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
        return rsp;
    endfunction

    // Random request, weighted toward hits on entries that are in the table.
    function automatic t_req random_request();
        t_req r;
        int   pick;
        int   load_pct;
        r.kind          = K_ACCESS;
        r.key_value     = $urandom();
        r.read_position = t_pos'($urandom_range(0, 31));
        pick     = $urandom_range(0, 99);
        // Load often while the table fills, rarely once it is full.
        load_pct = (tbl_len < DEPTH) ? 30 : 8;
        if (pick < load_pct) begin
            r.kind = K_LOAD;
        end else if (pick < load_pct + 15) begin
            r.kind = K_READ;
        end else if (pick < load_pct + 17) begin
            r.kind = K_UNUSED;
        end else if (pick < load_pct + 25 || tbl_len == 0) begin
            r.kind = K_ACCESS;
        end else begin
            r.key_value = tbl_value[$urandom_range(0, tbl_len - 1)];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic add_row(input logic [1:0] kind, input t_value key, input t_pos pos,
                           input int reps, input bit typed, input t_status st,
                           input t_pos at, input t_value val, input t_cnt_out cnt);
        t_directed_row row;
        row.req   = '{kind: kind, key_value: key, read_position: pos};
        row.reps  = reps;
        row.typed = typed;
        row.want  = '{status: st, position: at, entry_value: val, entry_count: cnt};
        directed_rows.push_back(row);
    endtask

    // Hold a request on the channel until it is taken, then record the
    // response it must produce. Raise valid again in the accept step when
    // there is no gap, so valid never drops between back-to-back requests.
    task automatic push_request(input t_req r, input bit typed, input t_rsp want);
        int   gap;
        t_rsp predicted;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!o_req_ready) @(posedge clk);
        // Advance the model even where the row carries its own answer.
        predicted = access_table(r);
        expected_rsp.push_back(typed ? want : predicted);
    endtask

    // Request side: reset, directed rows, random stretch, hot entry, drain.
    initial begin : req_side
        t_rsp   no_rsp;
        t_req   r;
        t_value hot_key;
        no_rsp = '0;

        // Extremes, each kind, misses, reads past the end and duplicates.
        add_row(K_READ,   32'h0000_0000, 5'd0,  1, 1'b1, ST_BEYOND,    5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h0000_0005, 5'd0,  1, 1'b1, ST_NOT_FOUND, 5'd0, 32'h5, 16'd0);
        add_row(K_UNUSED, 32'hFFFF_FFFF, 5'd31, 1, 1'b1, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_LOAD,   32'h7FFF_FFFF, 5'd0,  1, 1'b1, ST_OK,        5'd0, 32'h7FFF_FFFF, 16'd0);
        add_row(K_LOAD,   32'h8000_0000, 5'd0,  1, 1'b1, ST_OK,        5'd1, 32'h8000_0000, 16'd0);
        add_row(K_LOAD,   32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_LOAD,   32'hFFFF_FFFF, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        // Second copy of zero: access must always pick the first one.
        add_row(K_LOAD,   32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'hFFFF_FFFF, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'hFFFF_FFFF, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h8000_0000, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h0000_0000, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h7FFF_FFFF, 5'd0,  1, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_ACCESS, 32'h0000_3039, 5'd0,  1, 1'b1, ST_NOT_FOUND, 5'd0, 32'h3039, 16'd0);
        add_row(K_READ,   32'h0000_0000, 5'd31, 1, 1'b1, ST_BEYOND,    5'd0, 32'h0, 16'd0);
        // Walk every valid position.
        add_row(K_READ,   32'h0000_0000, 5'd0,  5, 1'b0, ST_OK,        5'd0, 32'h0, 16'd0);
        add_row(K_UNUSED, 32'h0000_0000, 5'd0,  1, 1'b1, ST_OK,        5'd0, 32'h0, 16'd0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            for (int k = 0; k < directed_rows[n].reps; k++) begin
                r = directed_rows[n].req;
                r.key_value     = r.key_value + k;
                r.read_position = r.read_position + t_pos'(k);
                push_request(r, directed_rows[n].typed, directed_rows[n].want);
            end
        end

        // Random stretch: fills the table, then reorders it. Toggle idling
        // in blocks so some stretches run back to back.
        for (int n = 0; n < 830; n++) begin
            if (n % 80 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
            end
            push_request(random_request(), 1'b0, no_rsp);
        end

        // Hammer one entry back to back so it climbs to the head.
        idle_on = 1'b0;
        hot_key = tbl_value[$urandom_range(0, tbl_len - 1)];
        r       = '{kind: K_ACCESS, key_value: hot_key, read_position: 5'd0};
        for (int n = 0; n < 40; n++) begin
            push_request(r, 1'b0, no_rsp);
        end

        // Reorder the rest around the hot entry.
        idle_on = 1'b1;
        for (int n = 0; n < 60; n++) begin
            push_request(random_request(), 1'b0, no_rsp);
        end
        req_valid <= 1'b0;

        while (expected_rsp.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Response side: stall at random, compare every response with the
    // oldest prediction.
    initial begin : rsp_side
        t_rsp want;
        int   gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                rsp_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!o_rsp_valid) @(posedge clk);
            if (expected_rsp.size() == 0) begin
                report_mismatch("response with none expected", o_rsp, 0);
            end else begin
                want = expected_rsp.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch("status", o_rsp.status, want.status);
                if (o_rsp.position !== want.position)
                    report_mismatch("position", o_rsp.position, want.position);
                if (o_rsp.entry_value !== want.entry_value)
                    report_mismatch("entry_value", o_rsp.entry_value, want.entry_value);
                if (o_rsp.entry_count !== want.entry_count)
                    report_mismatch("entry_count", o_rsp.entry_count, want.entry_count);
            end
        end
    end

    // Slowest correct run: about 950 requests, each with its busy time plus the
    // longest input gap and output stall. That stays under 0.7 ms. Allow about
    // seven times that.
    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
